@@ sv/cmkp_pkg.sv @@
`default_nettype none

package cmkp_pkg;

    // Widths fixed by the item and register formats.
    localparam int SAMPLE_BITS    = 16;
    localparam int PROD_BITS      = 2 * SAMPLE_BITS;
    localparam int RESP_BITS      = 37;
    localparam int KSEL_BITS      = 3;
    localparam int POS_BITS       = 10;
    localparam int REQ_BITS       = 2;
    localparam int IN_TDATA_BITS  = 56;
    localparam int OUT_TDATA_BITS = 40;
    localparam int CFG_ADDR_BITS  = 3;
    localparam int CFG_DATA_BITS  = 7;
    localparam int MAX_STRIDE     = 4;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_IMAGE_SIDE  = 64;
    localparam int DEF_MAX_KERNEL_SIDE = 7;
    localparam int DEF_MAX_KERNELS     = 8;

    // Register values after reset.
    localparam logic [6:0] RST_IMAGE_HEIGHT  = 7'd10;
    localparam logic [6:0] RST_IMAGE_WIDTH   = 7'd10;
    localparam logic [2:0] RST_WINDOW_HEIGHT = 3'd3;
    localparam logic [2:0] RST_WINDOW_WIDTH  = 3'd3;
    localparam logic [1:0] RST_PADDING       = 2'd0;
    localparam logic [2:0] RST_STEP_SIZE     = 3'd1;
    localparam logic [3:0] RST_KERNEL_COUNT  = 4'd8;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_WEIGHT  = 2'd0,
        REQ_PIXEL   = 2'd1,
        REQ_COMPUTE = 2'd2
    } t_req;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_IMAGE_HEIGHT  = 3'd0,
        CFG_IMAGE_WIDTH   = 3'd1,
        CFG_WINDOW_HEIGHT = 3'd2,
        CFG_WINDOW_WIDTH  = 3'd3,
        CFG_PADDING       = 3'd4,
        CFG_STEP_SIZE     = 3'd5,
        CFG_KERNEL_COUNT  = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TAPS,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    // Configuration after saturation into the legal ranges.
    typedef struct packed {
        logic [6:0] ih;
        logic [6:0] iw;
        logic [2:0] wh;
        logic [2:0] ww;
        logic [1:0] pad;
        logic [2:0] st;
        logic [3:0] kc;
    } t_cfg;

    // One tap issued to the multiply-accumulate unit.
    typedef struct packed {
        logic issue;
        logic first;
        logic zero;
    } t_mac_ctl;

endpackage

`default_nettype wire

@@ sv/cmkp_ram.sv @@
`default_nettype none

module cmkp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ sv/cmkp_mac.sv @@
`default_nettype none

module cmkp_mac (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire cmkp_pkg::t_mac_ctl                         i_ctl,
    input  wire logic signed [cmkp_pkg::SAMPLE_BITS-1:0]    i_pixel,
    input  wire logic signed [cmkp_pkg::SAMPLE_BITS-1:0]    i_weight,
    output logic signed      [cmkp_pkg::RESP_BITS-1:0]      o_acc,
    output logic                                            o_pending
);

    import cmkp_pkg::*;

    // Stage 1 lines up with the registered store read, stage 2 holds the product.
    t_mac_ctl                      r_ctl1;
    t_mac_ctl                      r_ctl2;
    logic signed [PROD_BITS-1:0]   r_prod;
    logic signed [PROD_BITS-1:0]   n_prod;
    logic signed [RESP_BITS-1:0]   r_acc;
    logic signed [RESP_BITS-1:0]   n_acc;

    always_comb begin
        // The product is formed on its own so that it stays a signed multiply.
        n_prod = i_pixel * i_weight;
        if (r_ctl1.zero) begin
            n_prod = '0;
        end
        n_acc  = r_ctl2.first ? RESP_BITS'(r_prod) : r_acc + RESP_BITS'(r_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (r_ctl2.issue) begin
            r_acc <= n_acc;
        end
    end

    // The final product lands in the accumulator at the edge that ends stage 2,
    // so only stage 1 needs to be empty before the sum is taken in the following cycle.
    assign o_pending = r_ctl1.issue;
    assign o_acc     = r_acc;

endmodule

`default_nettype wire

@@ sv/cmkp_seq.sv @@
`default_nettype none

module cmkp_seq #(
    parameter int MAX_IMAGE_SIDE  = cmkp_pkg::DEF_MAX_IMAGE_SIDE,
    parameter int MAX_KERNEL_SIDE = cmkp_pkg::DEF_MAX_KERNEL_SIDE,
    parameter int MAX_KERNELS     = cmkp_pkg::DEF_MAX_KERNELS,
    localparam int IR_W = (MAX_IMAGE_SIDE > 1) ? $clog2(MAX_IMAGE_SIDE) : 1,
    localparam int IA_W = (MAX_IMAGE_SIDE > 1) ? $clog2(MAX_IMAGE_SIDE * MAX_IMAGE_SIDE) : 1,
    localparam int WD   = MAX_KERNELS * MAX_KERNEL_SIDE * MAX_KERNEL_SIDE,
    localparam int WA_W = (WD > 1) ? $clog2(WD) : 1
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_rst_n,
    input  wire cmkp_pkg::t_cfg                           i_cfg,
    input  wire logic                                     i_in_valid,
    output logic                                          o_in_ready,
    input  wire logic [cmkp_pkg::REQ_BITS-1:0]            i_req,
    input  wire logic [6:0]                               i_out_row,
    input  wire logic [6:0]                               i_out_col,
    output logic      [IA_W-1:0]                          o_img_raddr,
    output logic      [WA_W-1:0]                          o_wgt_raddr,
    output cmkp_pkg::t_mac_ctl                            o_mac_ctl,
    input  wire logic signed [cmkp_pkg::RESP_BITS-1:0]    i_acc,
    input  wire logic                                     i_mac_pending,
    output logic                                          o_out_valid,
    input  wire logic                                     i_out_ready,
    output logic      [cmkp_pkg::KSEL_BITS-1:0]           o_out_kernel,
    output logic signed [cmkp_pkg::RESP_BITS-1:0]         o_out_resp,
    output logic                                          o_out_status,
    output logic                                          o_out_last
);

    import cmkp_pkg::*;

    localparam logic [WA_W-1:0] ROW_STEP    = WA_W'(MAX_KERNEL_SIDE);
    localparam logic [WA_W-1:0] KERNEL_STEP = WA_W'(MAX_KERNEL_SIDE * MAX_KERNEL_SIDE);

    t_state                 r_state, n_state;
    logic [3:0]             r_k, n_k;
    logic [2:0]             r_r, n_r;
    logic [2:0]             r_c, n_c;
    logic [WA_W-1:0]        r_kbase, n_kbase;
    logic [WA_W-1:0]        r_rowbase, n_rowbase;
    logic [POS_BITS-1:0]    r_base_r, n_base_r;
    logic [POS_BITS-1:0]    r_base_c, n_base_c;
    logic                   r_err, n_err;

    logic                   r_out_valid, n_out_valid;
    logic [KSEL_BITS-1:0]   r_out_kernel, n_out_kernel;
    logic signed [RESP_BITS-1:0] r_out_resp, n_out_resp;
    logic                   r_out_status, n_out_status;
    logic                   r_out_last, n_out_last;

    logic [POS_BITS-1:0]    pos_r, pos_c;
    logic [POS_BITS-1:0]    pad_ext;
    logic                   row_ok, col_ok;
    logic [IR_W-1:0]        row_idx, col_idx;
    logic [POS_BITS-1:0]    start_r, start_c;
    logic [POS_BITS-1:0]    span_r, span_c;
    logic                   pos_valid;
    logic                   last_c, last_r, last_k;
    logic                   out_free;
    logic                   take_compute;

    // Tap position in padded-image coordinates and its place in the store.
    always_comb begin
        pad_ext = POS_BITS'(i_cfg.pad);
        pos_r   = r_base_r + POS_BITS'(r_r);
        pos_c   = r_base_c + POS_BITS'(r_c);
        row_ok  = (pos_r >= pad_ext) && ((pos_r - pad_ext) < POS_BITS'(i_cfg.ih));
        col_ok  = (pos_c >= pad_ext) && ((pos_c - pad_ext) < POS_BITS'(i_cfg.iw));
        row_idx = IR_W'(pos_r - pad_ext);
        col_idx = IR_W'(pos_c - pad_ext);
        o_img_raddr = IA_W'(IA_W'(row_idx) * IA_W'(MAX_IMAGE_SIDE) + IA_W'(col_idx));
        o_wgt_raddr = r_rowbase + WA_W'(r_c);
    end

    // A position lies on the grid when its window ends inside the padded image.
    always_comb begin
        start_r   = POS_BITS'(i_out_row) * POS_BITS'(i_cfg.st);
        start_c   = POS_BITS'(i_out_col) * POS_BITS'(i_cfg.st);
        span_r    = POS_BITS'(i_cfg.ih) + POS_BITS'({i_cfg.pad, 1'b0});
        span_c    = POS_BITS'(i_cfg.iw) + POS_BITS'({i_cfg.pad, 1'b0});
        pos_valid = ((start_r + POS_BITS'(i_cfg.wh)) <= span_r)
                 && ((start_c + POS_BITS'(i_cfg.ww)) <= span_c);
    end

    assign last_c       = (r_c == 3'(i_cfg.ww - 3'd1));
    assign last_r       = (r_r == 3'(i_cfg.wh - 3'd1));
    assign last_k       = (4'(r_k + 4'd1) == i_cfg.kc);
    assign out_free     = !r_out_valid || i_out_ready;
    assign o_in_ready   = (r_state == ST_IDLE);
    assign take_compute = o_in_ready && i_in_valid && (i_req == REQ_COMPUTE);

    always_comb begin
        n_state      = r_state;
        n_k          = r_k;
        n_r          = r_r;
        n_c          = r_c;
        n_kbase      = r_kbase;
        n_rowbase    = r_rowbase;
        n_base_r     = r_base_r;
        n_base_c     = r_base_c;
        n_err        = r_err;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_kernel = r_out_kernel;
        n_out_resp   = r_out_resp;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        o_mac_ctl    = '0;

        case (r_state)
            ST_IDLE: begin
                if (take_compute) begin
                    n_base_r  = start_r;
                    n_base_c  = start_c;
                    n_err     = !pos_valid;
                    n_k       = '0;
                    n_r       = '0;
                    n_c       = '0;
                    n_kbase   = '0;
                    n_rowbase = '0;
                    n_state   = pos_valid ? ST_TAPS : ST_EMIT;
                end
            end
            ST_TAPS: begin
                o_mac_ctl.issue = 1'b1;
                o_mac_ctl.first = (r_r == 3'd0) && (r_c == 3'd0);
                o_mac_ctl.zero  = !(row_ok && col_ok);
                if (last_c) begin
                    n_c       = '0;
                    n_r       = 3'(r_r + 3'd1);
                    n_rowbase = r_rowbase + ROW_STEP;
                    if (last_r) begin
                        n_state = ST_DRAIN;
                    end
                end else begin
                    n_c = 3'(r_c + 3'd1);
                end
            end
            ST_DRAIN: begin
                if (!i_mac_pending) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    if (r_err) begin
                        n_out_kernel = '0;
                        n_out_resp   = '0;
                        n_out_status = 1'b1;
                        n_out_last   = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        n_out_kernel = KSEL_BITS'(r_k);
                        n_out_resp   = i_acc;
                        n_out_status = 1'b0;
                        n_out_last   = last_k;
                        if (last_k) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_k       = 4'(r_k + 4'd1);
                            n_kbase   = r_kbase + KERNEL_STEP;
                            n_rowbase = r_kbase + KERNEL_STEP;
                            n_r       = '0;
                            n_c       = '0;
                            n_state   = ST_TAPS;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k          <= n_k;
        r_r          <= n_r;
        r_c          <= n_c;
        r_kbase      <= n_kbase;
        r_rowbase    <= n_rowbase;
        r_base_r     <= n_base_r;
        r_base_c     <= n_base_c;
        r_err        <= n_err;
        r_out_kernel <= n_out_kernel;
        r_out_resp   <= n_out_resp;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_kernel = r_out_kernel;
    assign o_out_resp   = r_out_resp;
    assign o_out_status = r_out_status;
    assign o_out_last   = r_out_last;

endmodule

`default_nettype wire

@@ sv/conv2d_multi_kernel_padded.sv @@
`default_nettype none

// Channel    Direction  Handshake                      Contents
// s_axis     in         s_axis_tvalid / s_axis_tready  requests: writes and computes
// m_axis     out        m_axis_tvalid / m_axis_tready  a result per kernel (one if off grid), tlast on last
// cfg        in         i_cfg_we (no back-pressure)    register index and value
//
// A pixel or weight write leaves the block idle, so a new request can follow it. A compute
// is paced by the single multiply-accumulate unit that walks every tap of every kernel,
// and no new request is taken until its last result is issued; a position off the grid
// yields one error result. A result that is not taken holds the next kernel back.
// Reset is synchronous and active low; the stores hold no reset value.

module conv2d_multi_kernel_padded #(
    parameter int MAX_IMAGE_SIDE  = cmkp_pkg::DEF_MAX_IMAGE_SIDE,
    parameter int MAX_KERNEL_SIDE = cmkp_pkg::DEF_MAX_KERNEL_SIDE,
    parameter int MAX_KERNELS     = cmkp_pkg::DEF_MAX_KERNELS
) (
    input  wire logic                                       i_clk,
    input  wire logic                                       i_rst_n,
    input  wire logic                                       s_axis_tvalid,
    output logic                                            s_axis_tready,
    // pixel_row[5:0], pixel_col[11:6], out_row[18:12], out_col[25:19],
    // weight_kernel[28:26], tap_row[31:29], tap_col[34:32], sample[50:35], zero fill
    input  wire logic [cmkp_pkg::IN_TDATA_BITS-1:0]         s_axis_tdata,
    // req_type[1:0]
    input  wire logic [cmkp_pkg::REQ_BITS-1:0]              s_axis_tuser,
    output logic                                            m_axis_tvalid,
    input  wire logic                                       m_axis_tready,
    // result_kernel[2:0], response[39:3]
    output logic      [cmkp_pkg::OUT_TDATA_BITS-1:0]        m_axis_tdata,
    // status[0]
    output logic      [0:0]                                 m_axis_tuser,
    output logic                                            m_axis_tlast,
    input  wire logic                                       i_cfg_we,
    input  wire logic [cmkp_pkg::CFG_ADDR_BITS-1:0]         i_cfg_addr,
    input  wire logic [cmkp_pkg::CFG_DATA_BITS-1:0]         i_cfg_data
);

    import cmkp_pkg::*;

    localparam int IR_W = (MAX_IMAGE_SIDE > 1) ? $clog2(MAX_IMAGE_SIDE) : 1;
    localparam int ID   = MAX_IMAGE_SIDE * MAX_IMAGE_SIDE;
    localparam int IA_W = (ID > 1) ? $clog2(ID) : 1;
    localparam int WD   = MAX_KERNELS * MAX_KERNEL_SIDE * MAX_KERNEL_SIDE;
    localparam int WA_W = (WD > 1) ? $clog2(WD) : 1;

    logic [6:0] r_image_height;
    logic [6:0] r_image_width;
    logic [2:0] r_window_height;
    logic [2:0] r_window_width;
    logic [1:0] r_padding;
    logic [2:0] r_step_size;
    logic [3:0] r_kernel_count;

    t_cfg                          cfg;
    logic                          in_accept;
    logic [5:0]                    pixel_row, pixel_col;
    logic [6:0]                    out_row, out_col;
    logic [2:0]                    weight_kernel, tap_row, tap_col;
    logic signed [SAMPLE_BITS-1:0] sample;

    logic                          img_we, wgt_we;
    logic [IA_W-1:0]               img_waddr, img_raddr;
    logic [WA_W-1:0]               wgt_waddr, wgt_raddr;
    logic signed [SAMPLE_BITS-1:0] img_rdata, wgt_rdata;

    t_mac_ctl                      mac_ctl;
    logic signed [RESP_BITS-1:0]   acc;
    logic                          mac_pending;
    logic [KSEL_BITS-1:0]          out_kernel;
    logic signed [RESP_BITS-1:0]   out_resp;
    logic                          out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_height  <= RST_IMAGE_HEIGHT;
            r_image_width   <= RST_IMAGE_WIDTH;
            r_window_height <= RST_WINDOW_HEIGHT;
            r_window_width  <= RST_WINDOW_WIDTH;
            r_padding       <= RST_PADDING;
            r_step_size     <= RST_STEP_SIZE;
            r_kernel_count  <= RST_KERNEL_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_IMAGE_HEIGHT:  r_image_height  <= i_cfg_data;
                CFG_IMAGE_WIDTH:   r_image_width   <= i_cfg_data;
                CFG_WINDOW_HEIGHT: r_window_height <= i_cfg_data[2:0];
                CFG_WINDOW_WIDTH:  r_window_width  <= i_cfg_data[2:0];
                CFG_PADDING:       r_padding       <= i_cfg_data[1:0];
                CFG_STEP_SIZE:     r_step_size     <= i_cfg_data[2:0];
                CFG_KERNEL_COUNT:  r_kernel_count  <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // Registers hold what was written, cut to their widths; out-of-range values are saturated here.
    always_comb begin
        cfg.ih  = (r_image_height == 7'd0) ? 7'd1 :
                  (int'(r_image_height) > MAX_IMAGE_SIDE) ? 7'(MAX_IMAGE_SIDE) : r_image_height;
        cfg.iw  = (r_image_width == 7'd0) ? 7'd1 :
                  (int'(r_image_width) > MAX_IMAGE_SIDE) ? 7'(MAX_IMAGE_SIDE) : r_image_width;
        cfg.wh  = (r_window_height == 3'd0) ? 3'd1 :
                  (int'(r_window_height) > MAX_KERNEL_SIDE) ? 3'(MAX_KERNEL_SIDE)
                                                            : r_window_height;
        cfg.ww  = (r_window_width == 3'd0) ? 3'd1 :
                  (int'(r_window_width) > MAX_KERNEL_SIDE) ? 3'(MAX_KERNEL_SIDE)
                                                           : r_window_width;
        cfg.pad = r_padding;
        cfg.st  = (r_step_size == 3'd0) ? 3'd1 :
                  (int'(r_step_size) > MAX_STRIDE) ? 3'(MAX_STRIDE) : r_step_size;
        cfg.kc  = (r_kernel_count == 4'd0) ? 4'd1 :
                  (int'(r_kernel_count) > MAX_KERNELS) ? 4'(MAX_KERNELS) : r_kernel_count;
    end

    assign pixel_row     = s_axis_tdata[5:0];
    assign pixel_col     = s_axis_tdata[11:6];
    assign out_row       = s_axis_tdata[18:12];
    assign out_col       = s_axis_tdata[25:19];
    assign weight_kernel = s_axis_tdata[28:26];
    assign tap_row       = s_axis_tdata[31:29];
    assign tap_col       = s_axis_tdata[34:32];
    assign sample        = s_axis_tdata[50:35];

    assign in_accept = s_axis_tvalid && s_axis_tready;

    // Store writes complete in the transaction's own cycle.
    always_comb begin
        img_we    = in_accept && (s_axis_tuser == REQ_PIXEL)
                 && (int'(pixel_row) < MAX_IMAGE_SIDE) && (int'(pixel_col) < MAX_IMAGE_SIDE);
        img_waddr = IA_W'(IA_W'(IR_W'(pixel_row)) * IA_W'(MAX_IMAGE_SIDE)
                        + IA_W'(IR_W'(pixel_col)));
        wgt_we    = in_accept && (s_axis_tuser == REQ_WEIGHT)
                 && (int'(weight_kernel) < MAX_KERNELS)
                 && (int'(tap_row) < MAX_KERNEL_SIDE) && (int'(tap_col) < MAX_KERNEL_SIDE);
        wgt_waddr = WA_W'((WA_W'(weight_kernel) * WA_W'(MAX_KERNEL_SIDE) + WA_W'(tap_row))
                        * WA_W'(MAX_KERNEL_SIDE) + WA_W'(tap_col));
    end

    cmkp_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (ID)
    ) u_image_ram (
        .i_clk   (i_clk),
        .i_we    (img_we),
        .i_waddr (img_waddr),
        .i_wdata (sample),
        .i_raddr (img_raddr),
        .o_rdata (img_rdata)
    );

    cmkp_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WD)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (wgt_we),
        .i_waddr (wgt_waddr),
        .i_wdata (sample),
        .i_raddr (wgt_raddr),
        .o_rdata (wgt_rdata)
    );

    cmkp_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (mac_ctl),
        .i_pixel   (img_rdata),
        .i_weight  (wgt_rdata),
        .o_acc     (acc),
        .o_pending (mac_pending)
    );

    cmkp_seq #(
        .MAX_IMAGE_SIDE  (MAX_IMAGE_SIDE),
        .MAX_KERNEL_SIDE (MAX_KERNEL_SIDE),
        .MAX_KERNELS     (MAX_KERNELS)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_req         (s_axis_tuser),
        .i_out_row     (out_row),
        .i_out_col     (out_col),
        .o_img_raddr   (img_raddr),
        .o_wgt_raddr   (wgt_raddr),
        .o_mac_ctl     (mac_ctl),
        .i_acc         (acc),
        .i_mac_pending (mac_pending),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_kernel  (out_kernel),
        .o_out_resp    (out_resp),
        .o_out_status  (out_status),
        .o_out_last    (m_axis_tlast)
    );

    assign m_axis_tdata = {out_resp, out_kernel};
    assign m_axis_tuser = out_status;

endmodule

`default_nettype wire
